// ===== rtl/aabb_affine_transform_defines.svh =====
// Assertion macros used by the port-level checker of the box transform.
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define AAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, clocked on the rising edge, off during reset.
`define AAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/aat_pkg.sv =====
// Shared constants of the box transform: default widths and register map.
package aat_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int COEF_WIDTH_DEF  = 16;

	localparam int PADDR_WIDTH = 5;
	localparam int PDATA_WIDTH = 64;

	// Register index is byte address divided by eight.
	localparam int REG_IDX_LSB = 3;
	localparam logic [1:0] REG_ROW0 = 2'd0;
	localparam logic [1:0] REG_ROW1 = 2'd1;
	localparam logic [1:0] REG_ROW2 = 2'd2;

endpackage

// ===== rtl/aabb_affine_transform.sv =====
// Top level of the bounding box transform: register port and four-stage pipeline.
//
// Usage:
//   An item is a box (box_min_*, box_max_*) plus a translation (origin_*), all
//   signed Q16.16, taken when box_valid and box_ready are high at a clock edge.
//   The result item (out_min_*, out_max_*) is the axis-aligned box that encloses
//   the input box multiplied by the 3x3 matrix and moved by the origin, handed
//   over when result_valid and result_ready are high.
//   The matrix sits in three 48-bit row registers at byte addresses 0, 8 and 16
//   of the APB-style port; write them only while no item is in flight.
//   An item passes four register stages: centre and extent, eighteen products,
//   rounded column sums, then saturation into the output register. result_valid
//   is the valid bit of that last stage. Throughput is one item per cycle while
//   result_ready stays high. When the receiver stalls, each stage holds its item;
//   box_ready drops only once all four stages are full, and nothing is lost or
//   repeated. Reset clears every stage's valid bit and loads the identity matrix.
module aabb_affine_transform #(
	parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [aat_pkg::PADDR_WIDTH-1:0] paddr,
	input  logic [aat_pkg::PDATA_WIDTH-1:0] pwdata,
	output logic [aat_pkg::PDATA_WIDTH-1:0] prdata,
	output logic                             pready,
	input  logic                             box_valid,
	output logic                             box_ready,
	input  logic signed [COORD_WIDTH-1:0]    box_min_x,
	input  logic signed [COORD_WIDTH-1:0]    box_min_y,
	input  logic signed [COORD_WIDTH-1:0]    box_min_z,
	input  logic signed [COORD_WIDTH-1:0]    box_max_x,
	input  logic signed [COORD_WIDTH-1:0]    box_max_y,
	input  logic signed [COORD_WIDTH-1:0]    box_max_z,
	input  logic signed [COORD_WIDTH-1:0]    origin_x,
	input  logic signed [COORD_WIDTH-1:0]    origin_y,
	input  logic signed [COORD_WIDTH-1:0]    origin_z,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic signed [COORD_WIDTH-1:0]    out_min_x,
	output logic signed [COORD_WIDTH-1:0]    out_min_y,
	output logic signed [COORD_WIDTH-1:0]    out_min_z,
	output logic signed [COORD_WIDTH-1:0]    out_max_x,
	output logic signed [COORD_WIDTH-1:0]    out_max_y,
	output logic signed [COORD_WIDTH-1:0]    out_max_z
);

	localparam int CW = COORD_WIDTH;

	logic [3*COEF_WIDTH-1:0] rows [3];

	logic signed [CW-1:0] lo  [3];
	logic signed [CW-1:0] hi  [3];
	logic signed [CW-1:0] org [3];

	logic                 valid_s1;
	logic                 ready_s1;
	logic signed [CW-1:0] cen_s1 [3];
	logic        [CW-1:0] ext_s1 [3];
	logic signed [CW-1:0] org_s1 [3];

	logic                 valid_s3;
	logic                 ready_s3;
	logic        [CW+3:0] rad_s3 [3];
	logic signed [CW+4:0] cc_s3  [3];

	logic signed [CW-1:0] lo_s4 [3];
	logic signed [CW-1:0] hi_s4 [3];

	assign lo  = '{box_min_x, box_min_y, box_min_z};
	assign hi  = '{box_max_x, box_max_y, box_max_z};
	assign org = '{origin_x, origin_y, origin_z};

	aat_regs #(
		.COEF_WIDTH(COEF_WIDTH)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rows    (rows)
	);

	aat_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (box_valid),
		.up_ready (box_ready),
		.lo       (lo),
		.hi       (hi),
		.org      (org),
		.dn_valid (valid_s1),
		.dn_ready (ready_s1),
		.cen_s1   (cen_s1),
		.ext_s1   (ext_s1),
		.org_s1   (org_s1)
	);

	aat_dot #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEF_WIDTH (COEF_WIDTH)
	) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.rows     (rows),
		.up_valid (valid_s1),
		.up_ready (ready_s1),
		.cen_s1   (cen_s1),
		.ext_s1   (ext_s1),
		.org_s1   (org_s1),
		.dn_valid (valid_s3),
		.dn_ready (ready_s3),
		.rad_s3   (rad_s3),
		.cc_s3    (cc_s3)
	);

	aat_sat #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s3),
		.up_ready (ready_s3),
		.rad_s3   (rad_s3),
		.cc_s3    (cc_s3),
		.dn_valid (result_valid),
		.dn_ready (result_ready),
		.lo_s4    (lo_s4),
		.hi_s4    (hi_s4)
	);

	assign out_min_x = lo_s4[0];
	assign out_min_y = lo_s4[1];
	assign out_min_z = lo_s4[2];
	assign out_max_x = hi_s4[0];
	assign out_max_y = hi_s4[1];
	assign out_max_z = hi_s4[2];

endmodule

// ===== rtl/aat_regs.sv =====
// Matrix row registers behind the APB-style configuration port.
module aat_regs #(
	parameter int COEF_WIDTH = aat_pkg::COEF_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [aat_pkg::PADDR_WIDTH-1:0] paddr,
	input  logic [aat_pkg::PDATA_WIDTH-1:0] pwdata,
	output logic [aat_pkg::PDATA_WIDTH-1:0] prdata,
	output logic                             pready,
	output logic [3*COEF_WIDTH-1:0]          rows [3]
);

	localparam int RW = 3 * COEF_WIDTH;
	localparam int F  = COEF_WIDTH - 2;

	logic [RW-1:0] row_q [3];
	logic [1:0]    idx;
	logic          wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[aat_pkg::REG_IDX_LSB +: 2];
	assign wr_en  = psel && penable && pwrite && pready;

	// Reset is the identity: 1.0 on the diagonal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				row_q[j] <= RW'(1) << (COEF_WIDTH * j + F);
			end
		end else if (wr_en) begin
			unique case (idx)
				aat_pkg::REG_ROW0: row_q[0] <= pwdata[RW-1:0];
				aat_pkg::REG_ROW1: row_q[1] <= pwdata[RW-1:0];
				aat_pkg::REG_ROW2: row_q[2] <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			aat_pkg::REG_ROW0: prdata = aat_pkg::PDATA_WIDTH'(row_q[0]);
			aat_pkg::REG_ROW1: prdata = aat_pkg::PDATA_WIDTH'(row_q[1]);
			aat_pkg::REG_ROW2: prdata = aat_pkg::PDATA_WIDTH'(row_q[2]);
			default:           prdata = '0;
		endcase
	end

	assign rows = row_q;

endmodule

// ===== rtl/aat_prep.sv =====
// First pipeline stage: box centre and absolute half-extent per axis.
module aat_prep #(
	parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic signed [COORD_WIDTH-1:0] lo [3],
	input  logic signed [COORD_WIDTH-1:0] hi [3],
	input  logic signed [COORD_WIDTH-1:0] org [3],
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic signed [COORD_WIDTH-1:0] cen_s1 [3],
	output logic        [COORD_WIDTH-1:0] ext_s1 [3],
	output logic signed [COORD_WIDTH-1:0] org_s1 [3]
);

	localparam int CW = COORD_WIDTH;

	logic signed [CW:0]   sum [3];
	logic signed [CW-1:0] cen [3];
	logic signed [CW:0]   ext [3];
	logic        [CW:0]   mag [3];
	logic                 valid_s1;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum[j] = $signed({lo[j][CW-1], lo[j]}) + $signed({hi[j][CW-1], hi[j]});
			cen[j] = sum[j][CW:1];
			ext[j] = $signed({hi[j][CW-1], hi[j]}) - $signed({cen[j][CW-1], cen[j]});
			// The magnitude never exceeds 2^(CW-1), so CW bits hold it unsigned.
			mag[j] = ext[j][CW] ? (CW+1)'(-ext[j]) : ext[j];
		end
	end

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			for (int j = 0; j < 3; j++) begin
				cen_s1[j] <= cen[j];
				ext_s1[j] <= mag[j][CW-1:0];
				org_s1[j] <= org[j];
			end
		end
	end

endmodule

// ===== rtl/aat_dot.sv =====
// Second and third stages: eighteen products, then rounded column sums.
module aat_dot #(
	parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [3*COEF_WIDTH-1:0]       rows [3],
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic signed [COORD_WIDTH-1:0] cen_s1 [3],
	input  logic        [COORD_WIDTH-1:0] ext_s1 [3],
	input  logic signed [COORD_WIDTH-1:0] org_s1 [3],
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic        [COORD_WIDTH+3:0] rad_s3 [3],
	output logic signed [COORD_WIDTH+4:0] cc_s3 [3]
);

	localparam int CW = COORD_WIDTH;
	localparam int KW = COEF_WIDTH;
	localparam int F  = KW - 2;
	localparam int PW = CW + KW;
	localparam int SW = PW + 2;
	localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

	logic signed [KW-1:0] coef  [3][3];
	logic        [KW-1:0] acoef [3][3];

	logic        [PW-1:0] pa_s2 [3][3];
	logic signed [PW-1:0] pc_s2 [3][3];
	logic signed [CW-1:0] org_s2 [3];
	logic                 valid_s2;

	logic        [SW-1:0] sa [3];
	logic signed [SW-1:0] sc [3];
	logic signed [CW+4:0] cc [3];
	logic                 valid_s3;

	logic ready_s2;
	logic ready_s3;

	// coef[j][i] is row j, column i; the user must let the registers change only when no items flow (unenforced).
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				coef[j][i]  = $signed(rows[j][KW*i +: KW]);
				acoef[j][i] = coef[j][i][KW-1] ? KW'(-coef[j][i]) : coef[j][i];
			end
		end
	end

	assign ready_s3 = !valid_s3 || dn_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;
	assign dn_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= up_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && ready_s2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pa_s2[i][j] <= PW'(ext_s1[j]) * PW'(acoef[j][i]);
					pc_s2[i][j] <= $signed({{KW{cen_s1[j][CW-1]}}, cen_s1[j]})
						* $signed({{CW{coef[j][i][KW-1]}}, coef[j][i]});
				end
				org_s2[i] <= org_s1[i];
			end
		end
	end

	// Each sum is exact and rounded once: add half an LSB, then floor.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sa[i] = SW'(pa_s2[i][0]) + SW'(pa_s2[i][1]) + SW'(pa_s2[i][2]) + HALF;
			sc[i] = $signed({{2{pc_s2[i][0][PW-1]}}, pc_s2[i][0]})
				+ $signed({{2{pc_s2[i][1][PW-1]}}, pc_s2[i][1]})
				+ $signed({{2{pc_s2[i][2][PW-1]}}, pc_s2[i][2]})
				+ $signed(HALF);
			cc[i] = $signed({{5{org_s2[i][CW-1]}}, org_s2[i]})
				+ $signed({sc[i][SW-1], sc[i][SW-1:F]});
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			for (int i = 0; i < 3; i++) begin
				rad_s3[i] <= sa[i][SW-1:F];
				cc_s3[i]  <= cc[i];
			end
		end
	end

endmodule

// ===== rtl/aat_sat.sv =====
// Fourth stage: corners as centre minus and plus radius, saturated; output register.
module aat_sat #(
	parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic        [COORD_WIDTH+3:0] rad_s3 [3],
	input  logic signed [COORD_WIDTH+4:0] cc_s3 [3],
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic signed [COORD_WIDTH-1:0] lo_s4 [3],
	output logic signed [COORD_WIDTH-1:0] hi_s4 [3]
);

	localparam int CW = COORD_WIDTH;
	localparam int XW = CW + 6;
	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	logic signed [XW-1:0] lo_w [3];
	logic signed [XW-1:0] hi_w [3];
	logic signed [CW-1:0] lo_c [3];
	logic signed [CW-1:0] hi_c [3];
	logic                 valid_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo_w[i] = $signed({cc_s3[i][CW+4], cc_s3[i]}) - $signed({2'b00, rad_s3[i]});
			hi_w[i] = $signed({cc_s3[i][CW+4], cc_s3[i]}) + $signed({2'b00, rad_s3[i]});
			// A value fits when all bits from the sign of the narrow word up agree.
			if (&lo_w[i][XW-1:CW-1] || ~|lo_w[i][XW-1:CW-1]) begin
				lo_c[i] = lo_w[i][CW-1:0];
			end else begin
				lo_c[i] = lo_w[i][XW-1] ? MINV : MAXV;
			end
			if (&hi_w[i][XW-1:CW-1] || ~|hi_w[i][XW-1:CW-1]) begin
				hi_c[i] = hi_w[i][CW-1:0];
			end else begin
				hi_c[i] = hi_w[i][XW-1] ? MINV : MAXV;
			end
		end
	end

	assign up_ready = !valid_s4 || dn_ready;
	assign dn_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (up_ready) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			lo_s4 <= lo_c;
			hi_s4 <= hi_c;
		end
	end

endmodule

// ===== rtl/aat_checker.sv =====
// Port-level checker for the box transform and its bind to the top level.
`include "aabb_affine_transform_defines.svh"

module aat_checker #(
	parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [COORD_WIDTH-1:0] out_min_x,
	input logic signed [COORD_WIDTH-1:0] out_min_y,
	input logic signed [COORD_WIDTH-1:0] out_min_z,
	input logic signed [COORD_WIDTH-1:0] out_max_x,
	input logic signed [COORD_WIDTH-1:0] out_max_y,
	input logic signed [COORD_WIDTH-1:0] out_max_z
);

	// A stalled result item keeps its valid and all six corners.
	`AAT_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(out_min_x) && $stable(out_min_y) && $stable(out_min_z) && $stable(out_max_x) && $stable(out_max_y) && $stable(out_max_z), "stalled result item changed")

	// The radius is never negative, so every delivered box is ordered on each axis.
	`AAT_ASSERT_IMP(a_order_x, clk, arst_n, result_valid, out_min_x <= out_max_x, "x corners out of order")
	`AAT_ASSERT_IMP(a_order_y, clk, arst_n, result_valid, out_min_y <= out_max_y, "y corners out of order")
	`AAT_ASSERT_IMP(a_order_z, clk, arst_n, result_valid, out_min_z <= out_max_z, "z corners out of order")

endmodule

bind aabb_affine_transform aat_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_aat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.out_min_x    (out_min_x),
	.out_min_y    (out_min_y),
	.out_min_z    (out_min_z),
	.out_max_x    (out_max_x),
	.out_max_y    (out_max_y),
	.out_max_z    (out_max_z)
);

// ===== bench/aabb_affine_transform_checker.sv =====
`timescale 1ns / 100ps
// Checker for the box transform: follows the matrix writes, predicts each result box and compares.
module aabb_affine_transform_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic                                     pready,
	input  logic [aat_pkg::PADDR_WIDTH-1:0]          paddr,
	input  logic [aat_pkg::PDATA_WIDTH-1:0]          pwdata,
	input  logic                                     box_valid,
	input  logic                                     box_ready,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] box_min_x,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] box_min_y,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] box_min_z,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] box_max_x,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] box_max_y,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] box_max_z,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] origin_x,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] origin_y,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] origin_z,
	input  logic                                     result_valid,
	input  logic                                     result_ready,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] out_min_x,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] out_min_y,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] out_min_z,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] out_max_x,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] out_max_y,
	input  logic signed [aat_pkg::COORD_WIDTH_DEF-1:0] out_max_z,
	output int                                       fail_count,
	output int                                       in_flight
);

	localparam int CW    = aat_pkg::COORD_WIDTH_DEF;
	localparam int KW    = aat_pkg::COEF_WIDTH_DEF;
	localparam int FRAC  = KW - 2;
	localparam int ROW_W = 3 * KW;
	localparam longint HALF = longint'(1) << (FRAC - 1);

	typedef logic signed [CW-1:0] coord_t;
	typedef struct packed {
		coord_t min_x, min_y, min_z, max_x, max_y, max_z;
	} aabb_t;

	logic [ROW_W-1:0] mat_row [3];
	aabb_t expected_boxes [$];
	int mismatches;

	function automatic longint coef(int row, int col);
		return longint'($signed(mat_row[row][KW*col +: KW]));
	endfunction

	function automatic coord_t clamp_coord(longint v);
		longint top;
		top = (longint'(1) <<< (CW - 1)) - 1;
		if (v > top)
			return coord_t'(top);
		if (v < -top - 1)
			return coord_t'(-top - 1);
		return coord_t'(v);
	endfunction

	function automatic aabb_t transform_box(coord_t lo_x, coord_t lo_y, coord_t lo_z,
			coord_t hi_x, coord_t hi_y, coord_t hi_z,
			coord_t org_x, coord_t org_y, coord_t org_z);
		longint lo [3];
		longint hi [3];
		longint org [3];
		longint ctr [3];
		longint ext [3];
		longint rsum, csum, m, r, cc;
		coord_t out_lo [3];
		coord_t out_hi [3];
		lo[0] = lo_x; lo[1] = lo_y; lo[2] = lo_z;
		hi[0] = hi_x; hi[1] = hi_y; hi[2] = hi_z;
		org[0] = org_x; org[1] = org_y; org[2] = org_z;
		for (int j = 0; j < 3; j++) begin
			ctr[j] = (lo[j] + hi[j]) >>> 1;
			ext[j] = hi[j] - ctr[j];
			// An inverted box gives a negative extent; only its size matters.
			if (ext[j] < 0)
				ext[j] = -ext[j];
		end
		// All sums fit in 64 bits, so each is rounded once at full precision.
		for (int i = 0; i < 3; i++) begin
			rsum = 0;
			csum = 0;
			for (int j = 0; j < 3; j++) begin
				m = coef(j, i);
				csum += ctr[j] * m;
				rsum += ext[j] * (m < 0 ? -m : m);
			end
			r = (rsum + HALF) >>> FRAC;
			cc = org[i] + ((csum + HALF) >>> FRAC);
			out_lo[i] = clamp_coord(cc - r);
			out_hi[i] = clamp_coord(cc + r);
		end
		return {out_lo[0], out_lo[1], out_lo[2], out_hi[0], out_hi[1], out_hi[2]};
	endfunction

	task automatic check_field(string name, coord_t want, coord_t got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		aabb_t want;
		if (!arst_n) begin
			mat_row[0] = ROW_W'(1) << FRAC;
			mat_row[1] = ROW_W'(1) << (KW + FRAC);
			mat_row[2] = ROW_W'(1) << (2 * KW + FRAC);
			expected_boxes.delete();
			mismatches = 0;
			fail_count <= 0;
			in_flight <= 0;
		end else begin
			if (box_valid && box_ready)
				expected_boxes.push_back(transform_box(box_min_x, box_min_y, box_min_z,
					box_max_x, box_max_y, box_max_z, origin_x, origin_y, origin_z));
			if (result_valid && result_ready) begin
				if (expected_boxes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result box with no item outstanding", $time);
				end else begin
					want = expected_boxes.pop_front();
					check_field("out_min_x", want.min_x, out_min_x);
					check_field("out_min_y", want.min_y, out_min_y);
					check_field("out_min_z", want.min_z, out_min_z);
					check_field("out_max_x", want.max_x, out_max_x);
					check_field("out_max_y", want.max_y, out_max_y);
					check_field("out_max_z", want.max_z, out_max_z);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[aat_pkg::REG_IDX_LSB +: 2])
					aat_pkg::REG_ROW0: mat_row[0] = pwdata[ROW_W-1:0];
					aat_pkg::REG_ROW1: mat_row[1] = pwdata[ROW_W-1:0];
					aat_pkg::REG_ROW2: mat_row[2] = pwdata[ROW_W-1:0];
					default: ;
				endcase
			end
			fail_count <= mismatches;
			in_flight <= expected_boxes.size();
		end
	end

endmodule

// ===== bench/tb_aabb_affine_transform.sv =====
`timescale 1ns / 100ps
// Top of the box transform bench: clock, reset, matrix writes, item stimulus and verdict.
module tb_aabb_affine_transform;

	localparam int CW         = aat_pkg::COORD_WIDTH_DEF;
	localparam int KW         = aat_pkg::COEF_WIDTH_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 80;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct packed {
		coord_t min_x, min_y, min_z, max_x, max_y, max_z, org_x, org_y, org_z;
	} box_item_t;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [KW-1:0] COEF_ONE     = 1 << (KW - 2);
	localparam logic [KW-1:0] COEF_NEG_ONE = ~COEF_ONE + 1'b1;
	localparam logic [KW-1:0] COEF_MAX     = {1'b0, {(KW-1){1'b1}}};
	localparam logic [KW-1:0] COEF_MIN     = {1'b1, {(KW-1){1'b0}}};
	localparam logic [KW-1:0] COEF_ZERO    = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [aat_pkg::PADDR_WIDTH-1:0] paddr;
	logic [aat_pkg::PDATA_WIDTH-1:0] pwdata, prdata;
	logic box_valid, box_ready, result_valid, result_ready;
	coord_t box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z;
	coord_t origin_x, origin_y, origin_z;
	coord_t out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z;
	int fail_count, in_flight;
	int results_taken = 0;
	bit rx_stall_en = 1'b1;

	always #5 clk = ~clk;

	aabb_affine_transform DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.box_valid(box_valid), .box_ready(box_ready),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.result_valid(result_valid), .result_ready(result_ready),
		.out_min_x(out_min_x), .out_min_y(out_min_y), .out_min_z(out_min_z),
		.out_max_x(out_max_x), .out_max_y(out_max_y), .out_max_z(out_max_z)
	);

	aabb_affine_transform_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.box_valid(box_valid), .box_ready(box_ready),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.result_valid(result_valid), .result_ready(result_ready),
		.out_min_x(out_min_x), .out_min_y(out_min_y), .out_min_z(out_min_z),
		.out_max_x(out_max_x), .out_max_y(out_max_y), .out_max_z(out_max_z),
		.fail_count(fail_count), .in_flight(in_flight)
	);

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3, 4, 5: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic box_item_t make_box();
		coord_t lo [3];
		coord_t hi [3];
		coord_t org [3];
		coord_t t;
		bit zero_org;
		zero_org = ($urandom_range(0, 3) == 0);
		for (int j = 0; j < 3; j++) begin
			lo[j] = pick_coord();
			hi[j] = pick_coord();
			// Most boxes are ordered; a few keep the minimum above the maximum.
			if (lo[j] > hi[j] && $urandom_range(0, 7) != 0) begin
				t = lo[j];
				lo[j] = hi[j];
				hi[j] = t;
			end
			org[j] = zero_org ? coord_t'(0) : pick_coord();
		end
		return {lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], org[0], org[1], org[2]};
	endfunction

	function automatic box_item_t directed_box(int k);
		box_item_t b;
		b = '0;
		case (k)
			1: b = {{3{COORD_MIN}}, {3{COORD_MAX}}, {3{coord_t'(0)}}};
			2: b = {9{COORD_MAX}};
			3: b = {9{COORD_MIN}};
			4: b = {{3{coord_t'(32'h03E8_0000)}}, {3{coord_t'(32'hFC18_0000)}},
				{3{coord_t'(32'h0000_8000)}}};
			5: begin
				// Odd corner sums, so the halving has to floor toward minus infinity.
				b.min_x = -3; b.max_x = 0;
				b.min_y = -1; b.max_y = 0;
				b.min_z = 1;  b.max_z = 2;
				b.org_x = -1; b.org_y = 1; b.org_z = 0;
			end
			6: b = {{6{coord_t'(32'h1234_5678)}}, {3{COORD_MIN}}};
			7: b = {{6{coord_t'(-1)}}, {3{COORD_MAX}}};
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [63:0] make_row();
		logic [63:0] row;
		row = {$urandom, $urandom};
		for (int k = 0; k < 3; k++)
			case ($urandom_range(0, 5))
				0: row[KW*k +: KW] = COEF_MIN;
				1: row[KW*k +: KW] = COEF_MAX;
				2: row[KW*k +: KW] = COEF_ZERO;
				3, 4: row[KW*k +: KW] = KW'(int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE);
				default: row[KW*k +: KW] = KW'($urandom);
			endcase
		return row;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		logic [aat_pkg::PADDR_WIDTH-1:0] addr;
		addr = '0;
		addr[aat_pkg::REG_IDX_LSB +: 2] = idx;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2);
		write_reg(aat_pkg::REG_ROW0, r0);
		write_reg(aat_pkg::REG_ROW1, r1);
		write_reg(aat_pkg::REG_ROW2, r2);
	endtask

	task automatic offer_box(box_item_t b);
		{box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
			origin_x, origin_y, origin_z} <= b;
		box_valid <= 1'b1;
		do @(posedge clk); while (!box_ready);
	endtask

	task automatic send_items(int count, bit idle_on, bit directed);
		for (int n = 0; n < count; n++) begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				box_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			offer_box(directed ? directed_box(n) : make_box());
		end
		box_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic rx_tick();
		@(posedge clk);
		if (result_valid && result_ready)
			results_taken++;
	endtask

	// Receiver: random stalls, plus one long hold-off that backs the pipeline up to the input.
	// The hold-off starts well inside a random batch, so the sender still has items to offer.
	initial begin : drain
		bit held_long;
		held_long = 1'b0;
		result_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_long && results_taken >= 215) begin
				held_long = 1'b1;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) rx_tick();
			end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) rx_tick();
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) rx_tick();
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((box_valid && box_ready) || (result_valid && result_ready) ||
					(psel && penable && pwrite))
				quiet = 0;
			else
				quiet++;
		end
		$display("aabb_affine_transform regression: fail");
		$finish;
	end

	initial begin : stimulus
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		box_valid = 1'b0;
		{box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
			origin_x, origin_y, origin_z} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases under the reset identity, then under both coefficient extremes.
		send_items(8, 1'b0, 1'b1);
		wait_drained();
		set_matrix({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
		send_items(8, 1'b0, 1'b1);
		wait_drained();
		set_matrix({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
		send_items(8, 1'b0, 1'b1);

		for (int p = 0; p < 8; p++) begin
			if (p == 6)
				rx_stall_en = 1'b0;
			wait_drained();
			case (p)
				0: set_matrix('0, '0, '0);
				1: set_matrix({COEF_ZERO, COEF_ONE, COEF_ZERO},
					{COEF_ZERO, COEF_ZERO, COEF_NEG_ONE},
					{COEF_ONE, COEF_ZERO, COEF_ZERO});
				default: set_matrix(make_row(), make_row(), make_row());
			endcase
			send_items(60, p < 6, 1'b0);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && in_flight == 0)
			$display("aabb_affine_transform regression: pass");
		else
			$display("aabb_affine_transform regression: fail");
		$finish;
	end

endmodule
